// File: hw/rtl/lcsl_pkg.sv
// package for the longest common substring length block
// widths, input kind codes, controller states and the command and status bundles
// no dependencies
`default_nettype none

package lcsl_pkg;

  localparam int MAX_LEN = 64;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int KIND_W  = 2;
  localparam int SYM_W   = 8;
  localparam int OUT_W   = 7;

  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic append;
    logic start;
    logic scan;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic len_zero;
    logic out_blocked;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/lcsl_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module lcsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/lcsl_ctrl.sv
// controller: accepts beats, starts row scans and emits results
// depends on lcsl_pkg
`default_nettype none

module lcsl_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [lcsl_pkg::KIND_W-1:0] kind,
  input  lcsl_pkg::dp_status_t       status,
  output lcsl_pkg::ctrl_cmd_t        cmd
);
  import lcsl_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_ready = (state == ST_IDLE) && !((kind == KIND_END) && status.out_blocked);
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_SECOND) && !status.len_zero) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!status.scan_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.append = accept && (kind == KIND_FIRST);
        cmd.start  = accept && (kind == KIND_SECOND) && !status.len_zero;
        cmd.emit   = accept && (kind == KIND_END);
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/lcsl_dp.sv
// datapath: first-string buffer, dp row memory, scan pipeline, maximum and result register
// depends on lcsl_pkg and lcsl_ram
`default_nettype none

module lcsl_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lcsl_pkg::SYM_W-1:0]  symbol,
  input  lcsl_pkg::ctrl_cmd_t         cmd,
  output lcsl_pkg::dp_status_t        status,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [lcsl_pkg::OUT_W-1:0]  match_length,
  output logic                        overflow
);
  import lcsl_pkg::*;

  logic [LEN_W-1:0]  first_length;
  logic [LEN_W-1:0]  best_length;
  logic              dropped_flag;
  logic [LEN_W-1:0]  ptr;
  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  logic [SYM_W-1:0]  sym;
  logic [LEN_W-1:0]  prev;

  logic              room;
  logic              issue;
  logic [SYM_W-1:0]  str_q;
  logic [LEN_W-1:0]  row_q;
  logic [LEN_W-1:0]  run;
  logic              str_we;
  logic              row_we;
  logic [ADDR_W-1:0] row_waddr;
  logic [LEN_W-1:0]  row_wdata;
  logic [OUT_W-1:0]  best_sat;

  assign room  = first_length < LEN_W'(MAX_LEN);
  assign issue = cmd.scan && (ptr < first_length);
  assign run   = (str_q == sym) ? (prev + LEN_W'(1)) : '0;

  assign str_we    = cmd.append && room;
  assign row_we    = str_we || s1_valid;
  assign row_waddr = s1_valid ? s1_addr : first_length[ADDR_W-1:0];
  assign row_wdata = s1_valid ? run : '0;

  assign best_sat = (best_length > LEN_W'(127)) ? OUT_W'(127) : OUT_W'(best_length);

  assign status.scan_busy   = issue || s1_valid;
  assign status.len_zero    = (first_length == '0);
  assign status.out_blocked = result_valid && !result_ready;

  lcsl_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_str_ram (
    .clk   (clk),
    .we    (str_we),
    .waddr (first_length[ADDR_W-1:0]),
    .wdata (symbol),
    .raddr (ptr[ADDR_W-1:0]),
    .rdata (str_q)
  );

  lcsl_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (ptr[ADDR_W-1:0]),
    .rdata (row_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_length <= '0;
      best_length  <= '0;
      dropped_flag <= 1'b0;
      ptr          <= '0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (cmd.append) begin
        if (room) begin
          first_length <= first_length + LEN_W'(1);
        end else begin
          dropped_flag <= 1'b1;
        end
      end
      if (cmd.start) begin
        ptr      <= '0;
        s1_valid <= 1'b0;
      end
      if (cmd.scan) begin
        s1_valid <= issue;
        ptr      <= ptr + LEN_W'(issue);
      end
      if (s1_valid && (run > best_length)) begin
        best_length <= run;
      end
      if (cmd.emit) begin
        first_length <= '0;
        best_length  <= '0;
        dropped_flag <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sym  <= symbol;
      prev <= '0;
    end
    if (s1_valid) begin
      prev <= row_q;
    end
    s1_addr <= ptr[ADDR_W-1:0];
    if (cmd.emit) begin
      match_length <= best_sat;
      overflow     <= dropped_flag;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/longest_common_substring_length.sv
// top level of the longest common substring length block
// depends on lcsl_pkg, lcsl_ctrl, lcsl_dp
`default_nettype none

// Streams two byte strings and returns the length of their longest common
// contiguous substring. A first-string beat (kind 0) stores the byte, up to
// 64 bytes; further bytes are dropped and reported through overflow. A
// second-string beat (kind 1) walks the stored string once through the single
// read port of the buffer and row memories, updating one position per cycle,
// so it occupies the block until the whole stored string is walked; while
// nothing is stored it starts no walk. An end beat (kind 2) loads the result
// register and clears the pair; it waits while a scan is running or while an
// earlier result is still not taken. Kind 3 beats are accepted and ignored.
module longest_common_substring_length (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [lcsl_pkg::KIND_W-1:0] kind,
  input  logic [lcsl_pkg::SYM_W-1:0]  symbol,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [lcsl_pkg::OUT_W-1:0]  match_length,
  output logic                        overflow
);
  import lcsl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lcsl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .kind       (kind),
    .status     (status),
    .cmd        (cmd)
  );

  lcsl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .symbol       (symbol),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .match_length (match_length),
    .overflow     (overflow)
  );

endmodule

`default_nettype wire

// File: hw/rtl/lcsl_checker.sv
// port-level checks for the longest common substring length block
// depends on lcsl_pkg; bound to longest_common_substring_length
`default_nettype none

module lcsl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic [lcsl_pkg::KIND_W-1:0] kind,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [lcsl_pkg::OUT_W-1:0]  match_length,
  input logic                        overflow
);
  import lcsl_pkg::*;

  // stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(match_length) && $stable(overflow))
    else $error("result beat changed while stalled");

  // a result follows an end beat only
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && item_ready && (kind == KIND_END)))
    else $error("result without end beat");

  // length never beyond buffer capacity
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (match_length <= OUT_W'(MAX_LEN)))
    else $error("match length beyond capacity");

  // an end beat on a free output always yields a fresh result
  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (kind == KIND_END) |=> result_valid)
    else $error("end beat lost");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    $fell(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind longest_common_substring_length lcsl_checker u_lcsl_checker (.*);

`default_nettype wire
